// ===== src/ilb_pkg.sv =====
// ilb_pkg: types, constants and codes shared by the indexed list buffer
// no dependencies
package ilb_pkg;

	localparam int CAPACITY = 256;
	localparam int WORD_W   = 32;
	localparam int KIND_W   = 3;
	localparam int POS_W    = 8;
	localparam int STAT_W   = 2;
	localparam int OCNT_W   = 9;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int OEXT_W = (CNT_W > OCNT_W) ? CNT_W : OCNT_W;

	// read tree: sixteen groups of sixteen cover every reachable position
	localparam int GRP_N = 16;
	localparam int GRP_W = 4;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] REQ_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] REQ_SET    = 3'd3;
	localparam logic [KIND_W-1:0] REQ_GET    = 3'd4;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_APPEND,
		UPD_INSERT,
		UPD_REMOVE,
		UPD_SET
	} upd_op_t;

	typedef struct packed {
		upd_op_t           op;
		logic [POS_W-1:0]  idx;
		logic [CNT_W-1:0]  count;
		word_t             data;
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ1,
		S_READ2,
		S_APPLY
	} state_t;

endpackage

// ===== src/ilb_req_if.sv =====
// ilb_req_if: request channel of the indexed list buffer
// depends on ilb_pkg
interface ilb_req_if;
	logic                        valid;
	logic                        ready;
	logic [ilb_pkg::KIND_W-1:0]  req_type;
	logic [ilb_pkg::POS_W-1:0]   position;
	logic signed [ilb_pkg::WORD_W-1:0] element_data;

	modport source (output valid, req_type, position, element_data, input ready);
	modport sink (input valid, req_type, position, element_data, output ready);
endinterface

// ===== src/ilb_rsp_if.sv =====
// ilb_rsp_if: result channel of the indexed list buffer
// depends on ilb_pkg
interface ilb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ilb_pkg::STAT_W-1:0]  status;
	logic signed [ilb_pkg::WORD_W-1:0] read_data;
	logic [ilb_pkg::OCNT_W-1:0]  element_count;

	modport source (output valid, status, read_data, element_count, input ready);
	modport sink (input valid, status, read_data, element_count, output ready);
endinterface

// ===== src/indexed_list_buffer.sv =====
// indexed_list_buffer: fixed-capacity ordered list of signed words in a row of cells
// depends on ilb_pkg, ilb_req_if, ilb_rsp_if, ilb_cell, ilb_read_tree
//
//   channel  dir  fields                                   handshake
//   req      in   req_type, position, element_data         valid/ready
//   rsp      out  status, read_data, element_count         valid/ready
//
// an item passes through the idle (accept), read1 and read2 states, the read states going through the
// registered read tree, then the apply state in which every cell shifts, loads or holds at once
// a new item is accepted while the previous result still waits in the output register
// the apply cycle stalls while the output register holds a result not yet taken
// reset clears the count and the control; cell contents are undefined until written
module indexed_list_buffer (
	input  logic      clk,
	input  logic      arst_n,
	ilb_req_if.sink   req,
	ilb_rsp_if.source rsp
);

	ilb_pkg::state_t                state_q, state_d;
	logic [ilb_pkg::KIND_W-1:0]     kind_q;
	logic [ilb_pkg::POS_W-1:0]      pos_q;
	ilb_pkg::word_t                 data_q;
	logic [ilb_pkg::CNT_W-1:0]      count_q, count_d;

	logic                           out_valid_q;
	ilb_pkg::status_t               out_status_q, status_d;
	ilb_pkg::word_t                 out_data_q, rd_d;
	logic [ilb_pkg::OCNT_W-1:0]     out_count_q;
	logic [ilb_pkg::OEXT_W-1:0]     count_ext;

	logic                           take;
	logic                           apply;
	logic                           in_range;
	logic                           full;
	ilb_pkg::upd_op_t               op_d;
	ilb_pkg::cmd_t                  cmd;
	ilb_pkg::word_t                 cell_word [ilb_pkg::CAPACITY];
	ilb_pkg::word_t                 tree_word;

	assign take = req.valid && req.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		apply     = 1'b0;
		case (state_q)
			ilb_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_d = ilb_pkg::S_READ1;
			end
			ilb_pkg::S_READ1: state_d = ilb_pkg::S_READ2;
			ilb_pkg::S_READ2: state_d = ilb_pkg::S_APPLY;
			ilb_pkg::S_APPLY: begin
				if (!out_valid_q || rsp.ready) begin
					apply   = 1'b1;
					state_d = ilb_pkg::S_IDLE;
				end
			end
			default: state_d = ilb_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= req.req_type;
			pos_q  <= req.position;
			data_q <= req.element_data;
		end
	end

	assign in_range = ilb_pkg::CMP_W'(pos_q) < ilb_pkg::CMP_W'(count_q);
	assign full     = count_q == ilb_pkg::CNT_W'(ilb_pkg::CAPACITY);

	// index check comes before the full check for insert
	always_comb begin
		status_d = ilb_pkg::ST_OK;
		rd_d     = '0;
		op_d     = ilb_pkg::UPD_NONE;
		count_d  = count_q;
		case (kind_q)
			ilb_pkg::REQ_APPEND: begin
				if (full) status_d = ilb_pkg::ST_FULL;
				else begin
					op_d    = ilb_pkg::UPD_APPEND;
					count_d = count_q + ilb_pkg::CNT_W'(1);
				end
			end
			ilb_pkg::REQ_INSERT: begin
				if (!in_range) status_d = ilb_pkg::ST_INDEX;
				else if (full) status_d = ilb_pkg::ST_FULL;
				else begin
					op_d    = ilb_pkg::UPD_INSERT;
					count_d = count_q + ilb_pkg::CNT_W'(1);
				end
			end
			ilb_pkg::REQ_REMOVE: begin
				if (!in_range) status_d = ilb_pkg::ST_INDEX;
				else begin
					rd_d    = tree_word;
					op_d    = ilb_pkg::UPD_REMOVE;
					count_d = count_q - ilb_pkg::CNT_W'(1);
				end
			end
			ilb_pkg::REQ_SET: begin
				if (!in_range) status_d = ilb_pkg::ST_INDEX;
				else begin
					rd_d = tree_word;
					op_d = ilb_pkg::UPD_SET;
				end
			end
			ilb_pkg::REQ_GET: begin
				if (!in_range) status_d = ilb_pkg::ST_INDEX;
				else rd_d = tree_word;
			end
			default: status_d = ilb_pkg::ST_OK;
		endcase
	end

	assign cmd.op    = apply ? op_d : ilb_pkg::UPD_NONE;
	assign cmd.idx   = pos_q;
	assign cmd.count = count_q;
	assign cmd.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign count_ext = ilb_pkg::OEXT_W'(count_d);

	always_ff @(posedge clk) begin
		if (apply) begin
			out_status_q <= status_d;
			out_data_q   <= rd_d;
			out_count_q  <= count_ext[ilb_pkg::OCNT_W-1:0];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.read_data     = out_data_q;
	assign rsp.element_count = out_count_q;

	// the row of cells, each wired to its neighbors, with zero at either end of the row
	for (genvar i = 0; i < ilb_pkg::CAPACITY; i++) begin : g_cell
		ilb_pkg::word_t left_w;
		ilb_pkg::word_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_word[i-1];
		end
		if (i == ilb_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_word[i+1];
		end
		ilb_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.slot       (ilb_pkg::IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i])
		);
	end

	ilb_read_tree u_read_tree (
		.clk   (clk),
		.words (cell_word),
		.pos   (pos_q),
		.word  (tree_word)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ilb_pkg::CMP_W'(count_q) <= ilb_pkg::CMP_W'(ilb_pkg::CAPACITY))
		else $error("element count above capacity");

	a_count_moves_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(apply))
		else $error("element count changed outside the apply cycle");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ilb_pkg::S_APPLY))
		else $error("result shown without an apply cycle");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ilb_pkg::ST_FULL) |->
		count_q == ilb_pkg::CNT_W'(ilb_pkg::CAPACITY))
		else $error("full reported while the list has room");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ilb_pkg::ST_OK) |-> rsp.read_data == '0)
		else $error("error result carries data");
`endif

endmodule

// ===== src/ilb_cell.sv =====
// ilb_cell: one list slot; loads, holds or takes a neighbor's word
// depends on ilb_pkg
module ilb_cell (
	input  logic                       clk,
	input  ilb_pkg::cmd_t              cmd,
	input  logic [ilb_pkg::IDX_W-1:0]  slot,
	input  ilb_pkg::word_t             left_word,
	input  ilb_pkg::word_t             right_word,
	output ilb_pkg::word_t             word
);

	ilb_pkg::word_t               word_q;
	ilb_pkg::word_t               word_d;
	logic [ilb_pkg::CMP_W-1:0]    slot_x;
	logic [ilb_pkg::CMP_W-1:0]    slot_inc;
	logic [ilb_pkg::CMP_W-1:0]    idx_x;
	logic [ilb_pkg::CMP_W-1:0]    cnt_x;

	assign slot_x   = ilb_pkg::CMP_W'(slot);
	assign slot_inc = slot_x + ilb_pkg::CMP_W'(1);
	assign idx_x    = ilb_pkg::CMP_W'(cmd.idx);
	assign cnt_x    = ilb_pkg::CMP_W'(cmd.count);

	always_comb begin
		word_d = word_q;
		case (cmd.op)
			ilb_pkg::UPD_APPEND: begin
				if (slot_x == cnt_x) word_d = cmd.data;
			end
			ilb_pkg::UPD_INSERT: begin
				if (slot_x == idx_x) word_d = cmd.data;
				else if (slot_x > idx_x && slot_x <= cnt_x) word_d = left_word;
			end
			ilb_pkg::UPD_REMOVE: begin
				if (slot_x >= idx_x && slot_inc < cnt_x) word_d = right_word;
			end
			ilb_pkg::UPD_SET: begin
				if (slot_x == idx_x) word_d = cmd.data;
			end
			default: word_d = word_q;
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

// ===== src/ilb_read_tree.sv =====
// ilb_read_tree: two-stage registered select of the word at a position
// depends on ilb_pkg
module ilb_read_tree (
	input  logic                       clk,
	input  ilb_pkg::word_t             words [ilb_pkg::CAPACITY],
	input  logic [ilb_pkg::POS_W-1:0]  pos,
	output ilb_pkg::word_t             word
);

	ilb_pkg::word_t grp_d  [ilb_pkg::GRP_N];
	ilb_pkg::word_t grp_s1 [ilb_pkg::GRP_N];
	ilb_pkg::word_t word_s2;

	// low nibble picks within each group, slots past capacity read zero
	always_comb begin
		for (int g = 0; g < ilb_pkg::GRP_N; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < ilb_pkg::GRP_N; j++) begin
				if ((g * ilb_pkg::GRP_N + j) < ilb_pkg::CAPACITY &&
					pos[ilb_pkg::GRP_W-1:0] == ilb_pkg::GRP_W'(j)) begin
					grp_d[g] = words[ilb_pkg::IDX_W'(g * ilb_pkg::GRP_N + j)];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1  <= grp_d;
		word_s2 <= grp_s1[pos[ilb_pkg::POS_W-1:ilb_pkg::GRP_W]];
	end

	assign word = word_s2;

endmodule
